// File: sv/euler_rotation_matrix_builder_core_defines.svh
// ----------------------------------------------------------------------------
// Rotation matrix builder assertion macros
// Shared property forms for the checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef EULER_ROTATION_MATRIX_BUILDER_CORE_DEFINES_SVH
`define EULER_ROTATION_MATRIX_BUILDER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define ERB_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("rotation matrix builder check failed");

// next-cycle implication, sampled on clock, off during reset
`define ERB_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("rotation matrix builder check failed");

`endif

// File: sv/erb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix builder package
// Commands, pipeline stage numbering and the control groups between modules.
// ----------------------------------------------------------------------------
package erb_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD_FINE   = 2'd0,
      CMD_LOAD_COARSE = 2'd1,
      CMD_BUILD       = 2'd2
   } erb_command_type;

   localparam int TABLE_DEPTH = 256;
   localparam int NUM_ANGLES  = 3;
   localparam int NUM_ENTRIES = 9;

   localparam int ANGLE_FIRST  = 0;
   localparam int ANGLE_SECOND = 1;
   localparam int ANGLE_THIRD  = 2;

   localparam int STAGE_READ = 0;
   localparam int STAGE_PROD = 1;
   localparam int STAGE_TRIG = 2;
   localparam int STAGE_L1   = 3;
   localparam int STAGE_L2   = 4;
   localparam int STAGE_L3   = 5;
   localparam int STAGE_OUT  = 6;
   localparam int NUM_STAGES = 7;

   typedef struct packed {
      logic wr_fine;
      logic wr_coarse;
      logic load_read;
      logic load_prod;
      logic load_trig;
   } erb_lane_ctrl_type;

   typedef struct packed {
      logic load_l1;
      logic load_l2;
      logic load_l3;
      logic load_out;
   } erb_matrix_ctrl_type;

endpackage

// File: sv/erb_trig_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix builder sine and cosine lane
// Private copies of the coarse and fine tables, read on each read-stage load,
// then the correction products, the saturated sums and the half-turn cases.
// ----------------------------------------------------------------------------
module erb_trig_lane (
   input  logic                      clock,
   input  erb_pkg::erb_lane_ctrl_type ctrl,
   input  logic [7:0]                wr_index,
   input  logic signed [15:0]        wr_value,
   input  logic signed [15:0]        angle,
   output logic signed [15:0]        sin_value,
   output logic signed [15:0]        cos_value
);
   import erb_pkg::*;

   localparam logic [15:0]        HALF_TURN     = 16'h8000;
   localparam logic [7:0]         QUARTER_STEP  = 8'h40;
   localparam logic [7:0]         HALF_STEP     = 8'h80;
   localparam logic signed [18:0] SAT_HIGH      = 19'sd32767;
   localparam logic signed [18:0] SAT_LOW       = -19'sd32768;
   localparam logic signed [15:0] SAT_CLAMP_LOW = -16'sd32767;
   localparam logic signed [15:0] MIN_VALUE     = -16'sd32768;

   function automatic logic signed [15:0] sat_q15(input logic signed [18:0] v);
      logic signed [15:0] r;
      if (v > SAT_HIGH) begin
         r = 16'sh7fff;
      end else if (v < SAT_LOW) begin
         r = SAT_CLAMP_LOW;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

   logic signed [15:0] coarse_a_mem [TABLE_DEPTH];
   logic signed [15:0] coarse_b_mem [TABLE_DEPTH];
   logic signed [15:0] fine_mem     [TABLE_DEPTH];

   logic [15:0] mag;
   logic [7:0]  idx_base;
   logic [7:0]  idx_quarter;
   logic [7:0]  idx_half;

   logic signed [15:0] base_ff, quarter_ff, opposite_ff, fine_ff;
   logic               turn_ff, neg_ff;

   logic signed [16:0] opposite_neg;
   logic signed [31:0] prod_sin_in, prod_sin_ff;
   logic signed [32:0] prod_cos_in, prod_cos_ff;
   logic signed [15:0] base1_ff, quarter1_ff;
   logic               turn1_ff, neg1_ff;

   logic signed [18:0] sin_sum, cos_sum;
   logic signed [15:0] sin_sat, cos_sat;
   logic signed [15:0] sin_in, sin_ff, cos_in, cos_ff;

   assign mag         = angle[15] ? (16'd0 - angle) : angle;
   assign idx_base    = mag[15:8];
   assign idx_quarter = idx_base + QUARTER_STEP;
   assign idx_half    = idx_base + HALF_STEP;

   always_ff @(posedge clock) begin
      if (ctrl.wr_coarse) begin
         coarse_a_mem[wr_index] <= wr_value;
         coarse_b_mem[wr_index] <= wr_value;
      end
      if (ctrl.wr_fine) begin
         fine_mem[wr_index] <= wr_value;
      end
      if (ctrl.load_read) begin
         base_ff     <= coarse_a_mem[idx_base];
         quarter_ff  <= coarse_a_mem[idx_quarter];
         opposite_ff <= coarse_b_mem[idx_half];
         fine_ff     <= fine_mem[mag[7:0]];
         turn_ff     <= (angle == HALF_TURN);
         neg_ff      <= angle[15];
      end
   end

   assign opposite_neg = 17'sd0 - 17'(opposite_ff);
   assign prod_sin_in  = fine_ff * quarter_ff;
   assign prod_cos_in  = fine_ff * opposite_neg;

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_sin_ff <= prod_sin_in;
         prod_cos_ff <= prod_cos_in;
         base1_ff    <= base_ff;
         quarter1_ff <= quarter_ff;
         turn1_ff    <= turn_ff;
         neg1_ff     <= neg_ff;
      end
   end

   assign sin_sum = 19'(base1_ff) + 19'($signed(prod_sin_ff[31:15]));
   assign cos_sum = 19'(quarter1_ff) - 19'($signed(prod_cos_ff[32:15]));
   assign sin_sat = sat_q15(sin_sum);
   assign cos_sat = sat_q15(cos_sum);

   always_comb begin
      priority if (turn1_ff) begin
         sin_in = 16'sd0;
      end else if (neg1_ff) begin
         sin_in = 16'sd0 - sin_sat;
      end else begin
         sin_in = sin_sat;
      end
      cos_in = turn1_ff ? MIN_VALUE : cos_sat;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_trig) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_value = sin_ff;
   assign cos_value = cos_ff;

endmodule

// File: sv/erb_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix builder product pipeline
// Three multiply levels scaled by half the scale, then the final sums,
// each entry wrapped to 16 bits before the output register.
// ----------------------------------------------------------------------------
module erb_matrix (
   input  logic                        clock,
   input  erb_pkg::erb_matrix_ctrl_type ctrl,
   input  logic signed [14:0]          halved,
   input  logic signed [15:0]          sin_value [erb_pkg::NUM_ANGLES],
   input  logic signed [15:0]          cos_value [erb_pkg::NUM_ANGLES],
   output logic signed [15:0]          entry     [erb_pkg::NUM_ENTRIES],
   output logic signed [14:0]          halved_scale
);
   import erb_pkg::*;

   function automatic logic signed [16:0] mq(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
      logic signed [31:0] prod;
      prod = a * b;
      return $signed(prod[31:15]);
   endfunction

   logic signed [15:0] half16;

   // level one
   logic signed [15:0] hca_in, hsa_in, hsc_in, hcc_in, e2_in;
   logic signed [15:0] hca_ff, hsa_ff, hsc_ff, hcc_ff, e2_ff;
   logic signed [15:0] sb_ff, cb_ff, sc_ff, cc_ff;
   logic signed [14:0] half1_ff;

   // level two
   logic signed [15:0] hca_cc_in, hsa_sc_in, hsa_cc_in, hca_sc_in;
   logic signed [15:0] hca_cc_ff, hsa_sc_ff, hsa_cc_ff, hca_sc_ff;
   logic signed [15:0] e0_in, e1_in, e5_in, e8_in;
   logic signed [15:0] e0_ff, e1_ff, e5_ff, e8_ff, e2b_ff, sb2_ff;
   logic signed [14:0] half2_ff;

   // level three
   logic signed [16:0] p3_in, p4_in, p6_in, p7_in;
   logic signed [16:0] p3_ff, p4_ff, p6_ff, p7_ff;
   logic signed [15:0] hca_cc3_ff, hsa_sc3_ff, hsa_cc3_ff, hca_sc3_ff;
   logic signed [15:0] e0c_ff, e1c_ff, e2c_ff, e5c_ff, e8c_ff;
   logic signed [14:0] half3_ff;

   // output
   logic signed [15:0] e3_in, e4_in, e6_in, e7_in;
   logic signed [15:0] entry_ff [NUM_ENTRIES];
   logic signed [14:0] half_out_ff;

   assign half16 = 16'(halved);
   assign hca_in = 16'(mq(half16, cos_value[ANGLE_FIRST]));
   assign hsa_in = 16'(mq(half16, sin_value[ANGLE_FIRST]));
   assign e2_in  = 16'(mq(half16, sin_value[ANGLE_SECOND]));
   assign hsc_in = 16'(mq(half16, sin_value[ANGLE_THIRD]));
   assign hcc_in = 16'(mq(half16, cos_value[ANGLE_THIRD]));

   always_ff @(posedge clock) begin
      if (ctrl.load_l1) begin
         hca_ff   <= hca_in;
         hsa_ff   <= hsa_in;
         hsc_ff   <= hsc_in;
         hcc_ff   <= hcc_in;
         e2_ff    <= e2_in;
         sb_ff    <= sin_value[ANGLE_SECOND];
         cb_ff    <= cos_value[ANGLE_SECOND];
         sc_ff    <= sin_value[ANGLE_THIRD];
         cc_ff    <= cos_value[ANGLE_THIRD];
         half1_ff <= halved;
      end
   end

   assign hca_cc_in = 16'(mq(hca_ff, cc_ff));
   assign hsa_sc_in = 16'(mq(hsa_ff, sc_ff));
   assign hsa_cc_in = 16'(mq(hsa_ff, cc_ff));
   assign hca_sc_in = 16'(mq(hca_ff, sc_ff));
   assign e0_in     = 16'(mq(hca_ff, cb_ff));
   assign e1_in     = 16'(17'sd0 - mq(hsa_ff, cb_ff));
   assign e5_in     = 16'(17'sd0 - mq(hsc_ff, cb_ff));
   assign e8_in     = 16'(mq(hcc_ff, cb_ff));

   always_ff @(posedge clock) begin
      if (ctrl.load_l2) begin
         hca_cc_ff <= hca_cc_in;
         hsa_sc_ff <= hsa_sc_in;
         hsa_cc_ff <= hsa_cc_in;
         hca_sc_ff <= hca_sc_in;
         e0_ff     <= e0_in;
         e1_ff     <= e1_in;
         e5_ff     <= e5_in;
         e8_ff     <= e8_in;
         e2b_ff    <= e2_ff;
         sb2_ff    <= sb_ff;
         half2_ff  <= half1_ff;
      end
   end

   assign p3_in = mq(hca_sc_ff, sb2_ff);
   assign p4_in = mq(hsa_sc_ff, sb2_ff);
   assign p6_in = mq(hca_cc_ff, sb2_ff);
   assign p7_in = mq(hsa_cc_ff, sb2_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load_l3) begin
         p3_ff      <= p3_in;
         p4_ff      <= p4_in;
         p6_ff      <= p6_in;
         p7_ff      <= p7_in;
         hca_cc3_ff <= hca_cc_ff;
         hsa_sc3_ff <= hsa_sc_ff;
         hsa_cc3_ff <= hsa_cc_ff;
         hca_sc3_ff <= hca_sc_ff;
         e0c_ff     <= e0_ff;
         e1c_ff     <= e1_ff;
         e2c_ff     <= e2b_ff;
         e5c_ff     <= e5_ff;
         e8c_ff     <= e8_ff;
         half3_ff   <= half2_ff;
      end
   end

   assign e3_in = 16'(17'(hsa_cc3_ff) + p3_ff);
   assign e4_in = 16'(17'(hca_cc3_ff) - p4_ff);
   assign e6_in = 16'(17'(hsa_sc3_ff) - p6_ff);
   assign e7_in = 16'(17'(hca_sc3_ff) + p7_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         entry_ff[0] <= e0c_ff;
         entry_ff[1] <= e1c_ff;
         entry_ff[2] <= e2c_ff;
         entry_ff[3] <= e3_in;
         entry_ff[4] <= e4_in;
         entry_ff[5] <= e5c_ff;
         entry_ff[6] <= e6_in;
         entry_ff[7] <= e7_in;
         entry_ff[8] <= e8c_ff;
         half_out_ff <= half3_ff;
      end
   end

   assign entry        = entry_ff;
   assign halved_scale = half_out_ff;

endmodule

// File: sv/euler_rotation_matrix_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler angle rotation matrix builder core
// Q15 sine and cosine from loaded tables, then a scaled nine-entry matrix.
// ----------------------------------------------------------------------------
// One command is taken per cycle while req_stall is low, loads and builds
// alike. A build passes the READ, PROD, TRIG, L1, L2, L3 and OUT
// registers; each angle lane keeps its own copies of the tables so that all
// four table reads of an angle happen in the transfer cycle. A load writes
// every copy of its table at once and is seen by a build taken in the next
// cycle. The seven stages stall only as far back as the first empty stage,
// so requests are still taken while a matrix waits at the output. Tables
// hold no reset value; entries must be loaded before a build reads them.
`include "euler_rotation_matrix_builder_core_defines.svh"

module euler_rotation_matrix_builder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_table_index,
   input  logic signed [15:0] req_table_value,
   input  logic signed [15:0] req_scale,
   input  logic signed [15:0] req_angle_first,
   input  logic signed [15:0] req_angle_second,
   input  logic signed [15:0] req_angle_third,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_entry_0,
   output logic signed [15:0] rsp_entry_1,
   output logic signed [15:0] rsp_entry_2,
   output logic signed [15:0] rsp_entry_3,
   output logic signed [15:0] rsp_entry_4,
   output logic signed [15:0] rsp_entry_5,
   output logic signed [15:0] rsp_entry_6,
   output logic signed [15:0] rsp_entry_7,
   output logic signed [15:0] rsp_entry_8,
   output logic signed [14:0] rsp_halved_scale
);
   import erb_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, ready;
   logic                  req_accept;
   logic                  is_build;

   erb_lane_ctrl_type   lane_ctrl;
   erb_matrix_ctrl_type matrix_ctrl;

   logic signed [15:0] angle_bus [NUM_ANGLES];
   logic signed [15:0] sin_bus   [NUM_ANGLES];
   logic signed [15:0] cos_bus   [NUM_ANGLES];
   logic signed [15:0] entry_bus [NUM_ENTRIES];

   logic signed [14:0] halved_in, halved0_ff, halved1_ff, halved2_ff;

   always_comb begin
      ready[STAGE_OUT] = !valid_ff[STAGE_OUT] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign req_stall  = reset || !ready[STAGE_READ];
   assign req_accept = req_valid && !req_stall;
   assign is_build   = (req_command == CMD_BUILD);

   always_comb begin
      valid_in[STAGE_READ] = req_accept && is_build;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign halved_in = req_scale[15:1];

   always_ff @(posedge clock) begin
      if (ready[STAGE_READ]) begin
         halved0_ff <= halved_in;
      end
      if (ready[STAGE_PROD]) begin
         halved1_ff <= halved0_ff;
      end
      if (ready[STAGE_TRIG]) begin
         halved2_ff <= halved1_ff;
      end
   end

   always_comb begin
      lane_ctrl.wr_fine     = req_accept && (req_command == CMD_LOAD_FINE);
      lane_ctrl.wr_coarse   = req_accept && (req_command == CMD_LOAD_COARSE);
      lane_ctrl.load_read   = ready[STAGE_READ];
      lane_ctrl.load_prod   = ready[STAGE_PROD];
      lane_ctrl.load_trig   = ready[STAGE_TRIG];
      matrix_ctrl.load_l1   = ready[STAGE_L1];
      matrix_ctrl.load_l2   = ready[STAGE_L2];
      matrix_ctrl.load_l3   = ready[STAGE_L3];
      matrix_ctrl.load_out  = ready[STAGE_OUT];
   end

   assign angle_bus[ANGLE_FIRST]  = req_angle_first;
   assign angle_bus[ANGLE_SECOND] = req_angle_second;
   assign angle_bus[ANGLE_THIRD]  = req_angle_third;

   for (genvar g = 0; g < NUM_ANGLES; g++) begin : g_lane
      erb_trig_lane u_lane (
         .clock     (clock),
         .ctrl      (lane_ctrl),
         .wr_index  (req_table_index),
         .wr_value  (req_table_value),
         .angle     (angle_bus[g]),
         .sin_value (sin_bus[g]),
         .cos_value (cos_bus[g])
      );
   end

   erb_matrix u_matrix (
      .clock        (clock),
      .ctrl         (matrix_ctrl),
      .halved       (halved2_ff),
      .sin_value    (sin_bus),
      .cos_value    (cos_bus),
      .entry        (entry_bus),
      .halved_scale (rsp_halved_scale)
   );

   assign rsp_valid   = valid_ff[STAGE_OUT];
   assign rsp_entry_0 = entry_bus[0];
   assign rsp_entry_1 = entry_bus[1];
   assign rsp_entry_2 = entry_bus[2];
   assign rsp_entry_3 = entry_bus[3];
   assign rsp_entry_4 = entry_bus[4];
   assign rsp_entry_5 = entry_bus[5];
   assign rsp_entry_6 = entry_bus[6];
   assign rsp_entry_7 = entry_bus[7];
   assign rsp_entry_8 = entry_bus[8];

   `ERB_ASSERT_NEXT(a_build_enters_pipe, req_valid && !req_stall, valid_ff[STAGE_READ] == $past(req_command == CMD_BUILD))
   `ERB_ASSERT_NOW(a_stall_only_when_full, req_stall, (&valid_ff) && rsp_stall)
   `ERB_ASSERT_NEXT(a_held_stage_kept, valid_ff[STAGE_L2] && !ready[STAGE_L2], valid_ff[STAGE_L2])

endmodule
